// ===== hdl/bracket_match_number_lexer_defines.svh =====
// Assertion macros shared by the lexer RTL.
`ifndef BRACKET_MATCH_NUMBER_LEXER_DEFINES_SVH
`define BRACKET_MATCH_NUMBER_LEXER_DEFINES_SVH

// Check a condition in the same cycle as its trigger
`define BMNL_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Check a condition in the cycle after its trigger
`define BMNL_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/bmnl_pkg.sv =====
package bmnl_pkg;

    // Event codes of a result item
    typedef enum logic [3:0] {
        EV_OPEN        = 4'd0,
        EV_CLOSE_MATCH = 4'd1,
        EV_OPERATOR    = 4'd2,
        EV_NUMBER      = 4'd3,
        EV_MISMATCH    = 4'd4,
        EV_CLOSE_EMPTY = 4'd5,
        EV_UNCLOSED    = 4'd6,
        EV_OVERFLOW    = 4'd7,
        EV_END_OK      = 4'd8
    } ev_t;

    // Bracket kinds held on the stack
    localparam logic [1:0] BR_PAREN  = 2'd0;
    localparam logic [1:0] BR_SQUARE = 2'd1;
    localparam logic [1:0] BR_CURLY  = 2'd2;

    // Character codes
    localparam logic [7:0] CH_LPAREN = 8'd40;
    localparam logic [7:0] CH_RPAREN = 8'd41;
    localparam logic [7:0] CH_STAR   = 8'd42;
    localparam logic [7:0] CH_PLUS   = 8'd43;
    localparam logic [7:0] CH_MINUS  = 8'd45;
    localparam logic [7:0] CH_POINT  = 8'd46;
    localparam logic [7:0] CH_SLASH  = 8'd47;
    localparam logic [7:0] CH_ZERO   = 8'd48;
    localparam logic [7:0] CH_NINE   = 8'd57;
    localparam logic [7:0] CH_LBRACK = 8'd91;
    localparam logic [7:0] CH_RBRACK = 8'd93;
    localparam logic [7:0] CH_LBRACE = 8'd123;
    localparam logic [7:0] CH_RBRACE = 8'd125;

    // Fraction digit count saturates here
    localparam logic [3:0] FRAC_MAX = 4'd15;

    // Result queue depth (power of two, at least two)
    localparam int RES_DEPTH = 4;

    // Stack control from the decoder
    typedef struct packed {
        logic       push;
        logic       pop;
        logic       clear;
        logic [1:0] code;
    } stack_cmd_t;

    // Stack status to the decoder
    typedef struct packed {
        logic       empty;
        logic       full;
        logic       single;
        logic [1:0] top;
    } stack_stat_t;

    // Number accumulator control from the decoder
    typedef struct packed {
        logic       digit_en;
        logic       point_en;
        logic       clear;
        logic [3:0] digit;
    } num_cmd_t;

endpackage

// ===== hdl/bmnl_stack.sv =====
module bmnl_stack #(
    parameter int DEPTH = 64
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  bmnl_pkg::stack_cmd_t cmd,
    output bmnl_pkg::stack_stat_t stat
);

    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // Entries below the top two live in memory; top and the one under it in registers
    logic [1:0]       mem [DEPTH];
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [1:0]       top_reg;
    logic [1:0]       under_reg;
    logic [CNT_W-1:0] wr_idx;
    logic [CNT_W-1:0] rd_idx;

    assign wr_idx = count_reg - CNT_W'(1);
    assign rd_idx = count_reg - CNT_W'(3);

    // Status for the decoder
    assign stat.empty  = (count_reg == '0);
    assign stat.full   = (count_reg == CNT_W'(DEPTH));
    assign stat.single = (count_reg == CNT_W'(1));
    assign stat.top    = top_reg;

    // Advance the fill count
    always_comb begin
        priority if (cmd.clear) begin
            count_next = '0;
        end else if (cmd.push) begin
            count_next = count_reg + CNT_W'(1);
        end else if (cmd.pop) begin
            count_next = count_reg - CNT_W'(1);
        end else begin
            count_next = count_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // Spill the old top on push, refill the entry under the top on pop
    always_ff @(posedge aclk) begin
        if (!cmd.clear) begin
            if (cmd.push) begin
                if (count_reg != '0) begin
                    mem[wr_idx[ADDR_W-1:0]] <= top_reg;
                end
                under_reg <= top_reg;
                top_reg   <= cmd.code;
            end else if (cmd.pop) begin
                under_reg <= mem[rd_idx[ADDR_W-1:0]];
                top_reg   <= under_reg;
            end
        end
    end

endmodule

// ===== hdl/bmnl_number.sv =====
module bmnl_number #(
    parameter int MANT_BITS = 40
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  bmnl_pkg::num_cmd_t   cmd,
    output logic [MANT_BITS-1:0] mant_upd,
    output logic [3:0]           frac_upd,
    output logic                 in_num_upd
);

    logic [MANT_BITS-1:0] acc_reg;
    logic [MANT_BITS-1:0] acc_next;
    logic [3:0]           frac_reg;
    logic [3:0]           frac_next;
    logic                 in_frac_reg;
    logic                 in_frac_next;
    logic                 in_num_reg;
    logic                 in_num_next;
    logic                 in_frac_upd;
    logic [MANT_BITS+3:0] prod;
    logic                 sat;

    // Multiply by ten and add the digit, saturating at all ones
    assign prod = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1)
                + (MANT_BITS + 4)'(cmd.digit);
    assign sat  = |prod[MANT_BITS+3:MANT_BITS];

    // Number state after this character, before any flush
    always_comb begin
        mant_upd    = acc_reg;
        frac_upd    = frac_reg;
        in_frac_upd = in_frac_reg;
        in_num_upd  = in_num_reg;
        if (cmd.digit_en) begin
            in_num_upd = 1'b1;
            if (!(in_frac_reg && frac_reg == bmnl_pkg::FRAC_MAX)) begin
                frac_upd = frac_reg + {3'b0, in_frac_reg};
                mant_upd = sat ? '1 : prod[MANT_BITS-1:0];
            end
        end else if (cmd.point_en) begin
            in_num_upd  = 1'b1;
            in_frac_upd = 1'b1;
        end
    end

    // Drop the number once it has been emitted
    always_comb begin
        if (cmd.clear) begin
            acc_next     = '0;
            frac_next    = '0;
            in_frac_next = 1'b0;
            in_num_next  = 1'b0;
        end else begin
            acc_next     = mant_upd;
            frac_next    = frac_upd;
            in_frac_next = in_frac_upd;
            in_num_next  = in_num_upd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg     <= '0;
            frac_reg    <= '0;
            in_frac_reg <= 1'b0;
            in_num_reg  <= 1'b0;
        end else begin
            acc_reg     <= acc_next;
            frac_reg    <= frac_next;
            in_frac_reg <= in_frac_next;
            in_num_reg  <= in_num_next;
        end
    end

endmodule

// ===== hdl/bmnl_res_fifo.sv =====
module bmnl_res_fifo #(
    parameter int W     = 57,
    parameter int DEPTH = 4
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic [1:0]   wr_n,
    input  logic [W-1:0] wr_data0,
    input  logic [W-1:0] wr_data1,
    output logic         room2,
    output logic         rd_valid,
    input  logic         rd_ready,
    output logic [W-1:0] rd_data
);

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    logic [W-1:0]      entries [DEPTH];
    logic [ADDR_W-1:0] wp_reg;
    logic [ADDR_W-1:0] wp_next;
    logic [ADDR_W-1:0] wp_plus1;
    logic [ADDR_W-1:0] rp_reg;
    logic [ADDR_W-1:0] rp_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              pop;

    assign wp_plus1 = wp_reg + ADDR_W'(1);
    assign pop      = rd_valid && rd_ready;
    assign rd_valid = (count_reg != '0);
    assign rd_data  = entries[rp_reg];
    assign room2    = (count_reg <= CNT_W'(DEPTH - 2));

    // Advance pointers and fill count
    always_comb begin
        wp_next    = wp_reg + ADDR_W'(wr_n);
        rp_next    = rp_reg + ADDR_W'(pop);
        count_next = count_reg + CNT_W'(wr_n) - CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg    <= '0;
            rp_reg    <= '0;
            count_reg <= '0;
        end else begin
            wp_reg    <= wp_next;
            rp_reg    <= rp_next;
            count_reg <= count_next;
        end
    end

    // Store up to two result items per cycle
    always_ff @(posedge aclk) begin
        if (wr_n != 2'd0) begin
            entries[wp_reg] <= wr_data0;
        end
        if (wr_n == 2'd2) begin
            entries[wp_plus1] <= wr_data1;
        end
    end

endmodule

// ===== hdl/bracket_match_number_lexer.sv =====
// Bracket matcher and decimal number lexer. Each input item is one ASCII
// character (s_tdata) with s_tlast marking the last character of an
// expression. Results arrive on the m_ side: m_tuser carries the event code,
// m_tdata the symbol, the saturating integer mantissa and the count of
// fraction digits, and m_tlast flags the final result caused by an input item.
// All decoding, the bracket stack update and the multiply-by-ten accumulate
// are done in the cycle an item is accepted, so one item is taken every clock
// while the four-entry result queue has room for two results. An item that
// gives two results needs two transfers on the m_ port, so a long run of such
// items is held back by the single result port. Brackets nest up to
// STACK_DEPTH deep; the stack keeps its top two entries in registers and the
// rest in a memory with a registered read. After an error the block swallows
// input up to the next last item and then starts clean; no clearing pass is
// needed after reset.
`include "bracket_match_number_lexer_defines.svh"

module bracket_match_number_lexer #(
    parameter int STACK_DEPTH = 64,
    parameter int MANT_BITS   = 40
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,  // [7:0] ch
    input  logic                  s_tlast,  // end_of_expr
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [((12 + MANT_BITS + 7) / 8) * 8 - 1:0] m_tdata,
                                            // symbol, mantissa, frac_digits, zero fill
    output logic [3:0]            m_tuser,  // [3:0] event_res
    output logic                  m_tlast   // last_of_run
);

    localparam int TDATA_W = ((12 + MANT_BITS + 7) / 8) * 8;
    localparam int RES_W   = 4 + 8 + MANT_BITS + 4 + 1;

    logic                   acc;
    logic                   last;
    logic [7:0]             ch;
    logic [7:0]             digit_off;
    logic                   is_digit;
    logic                   is_point;
    logic                   is_open;
    logic                   is_close;
    logic                   is_op;
    logic [1:0]             code;
    logic                   halt_reg;
    logic                   halt_next;
    bmnl_pkg::stack_cmd_t   stk_cmd;
    bmnl_pkg::stack_stat_t  stk_stat;
    bmnl_pkg::num_cmd_t     num_cmd;
    logic [MANT_BITS-1:0]   mant_upd;
    logic [3:0]             frac_upd;
    logic                   in_num_upd;
    bmnl_pkg::ev_t          ev;
    logic                   ev_valid;
    logic                   err;
    logic                   open_after;
    logic                   have_num;
    logic                   emit_ev;
    logic                   have_end;
    logic [1:0]             res_n;
    logic [1:0]             wr_n;
    bmnl_pkg::ev_t          end_ev;
    logic [RES_W-2:0]       num_res;
    logic [RES_W-2:0]       ev_res;
    logic [RES_W-2:0]       end_res;
    logic [RES_W-1:0]       res0;
    logic [RES_W-1:0]       res1;
    logic [RES_W-1:0]       rd_res;
    logic                   room2;

    assign acc  = s_tvalid && s_tready;
    assign last = s_tlast;
    assign ch   = s_tdata;

    // Classify the character
    assign digit_off = ch - bmnl_pkg::CH_ZERO;
    assign is_digit  = (ch >= bmnl_pkg::CH_ZERO) && (ch <= bmnl_pkg::CH_NINE);
    assign is_point  = (ch == bmnl_pkg::CH_POINT);
    assign is_open   = (ch == bmnl_pkg::CH_LPAREN) || (ch == bmnl_pkg::CH_LBRACK)
                    || (ch == bmnl_pkg::CH_LBRACE);
    assign is_close  = (ch == bmnl_pkg::CH_RPAREN) || (ch == bmnl_pkg::CH_RBRACK)
                    || (ch == bmnl_pkg::CH_RBRACE);
    assign is_op     = (ch == bmnl_pkg::CH_STAR) || (ch == bmnl_pkg::CH_PLUS)
                    || (ch == bmnl_pkg::CH_MINUS) || (ch == bmnl_pkg::CH_SLASH);

    always_comb begin
        priority if (ch == bmnl_pkg::CH_LPAREN || ch == bmnl_pkg::CH_RPAREN) begin
            code = bmnl_pkg::BR_PAREN;
        end else if (ch == bmnl_pkg::CH_LBRACK || ch == bmnl_pkg::CH_RBRACK) begin
            code = bmnl_pkg::BR_SQUARE;
        end else begin
            code = bmnl_pkg::BR_CURLY;
        end
    end

    // Bracket and operator event of this character
    always_comb begin
        ev         = bmnl_pkg::EV_OPERATOR;
        ev_valid   = 1'b0;
        err        = 1'b0;
        open_after = !stk_stat.empty;
        priority if (is_open) begin
            ev_valid = 1'b1;
            if (stk_stat.full) begin
                ev  = bmnl_pkg::EV_OVERFLOW;
                err = 1'b1;
            end else begin
                ev         = bmnl_pkg::EV_OPEN;
                open_after = 1'b1;
            end
        end else if (is_close) begin
            ev_valid = 1'b1;
            if (stk_stat.empty) begin
                ev  = bmnl_pkg::EV_CLOSE_EMPTY;
                err = 1'b1;
            end else begin
                open_after = !stk_stat.single;
                if (stk_stat.top == code) begin
                    ev = bmnl_pkg::EV_CLOSE_MATCH;
                end else begin
                    ev  = bmnl_pkg::EV_MISMATCH;
                    err = 1'b1;
                end
            end
        end else if (is_op) begin
            ev_valid = 1'b1;
        end else begin
            ev_valid = 1'b0;
        end
    end

    // Drive the stack and the number accumulator
    assign stk_cmd.push  = acc && !halt_reg && is_open && !stk_stat.full;
    assign stk_cmd.pop   = acc && !halt_reg && is_close && !stk_stat.empty;
    assign stk_cmd.clear = acc && last;
    assign stk_cmd.code  = code;

    assign num_cmd.digit_en = acc && !halt_reg && is_digit;
    assign num_cmd.point_en = acc && !halt_reg && is_point;
    assign num_cmd.clear    = acc && (last || !(is_digit || is_point));
    assign num_cmd.digit    = digit_off[3:0];

    bmnl_stack #(
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (stk_cmd),
        .stat    (stk_stat)
    );

    bmnl_number #(
        .MANT_BITS (MANT_BITS)
    ) u_number (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (num_cmd),
        .mant_upd   (mant_upd),
        .frac_upd   (frac_upd),
        .in_num_upd (in_num_upd)
    );

    // Pick the results: pending number, own event, end event
    assign have_num = !halt_reg && in_num_upd && (last || !(is_digit || is_point));
    assign emit_ev  = !halt_reg && ev_valid && (err || !last || !have_num);
    assign have_end = !halt_reg && last && !err;
    assign end_ev   = open_after ? bmnl_pkg::EV_UNCLOSED : bmnl_pkg::EV_END_OK;
    assign res_n    = 2'(have_num) + 2'(emit_ev) + 2'(have_end);
    assign wr_n     = acc ? res_n : 2'd0;

    assign num_res = {frac_upd, mant_upd, 8'd0, bmnl_pkg::EV_NUMBER};
    assign ev_res  = {4'd0, {MANT_BITS{1'b0}}, ch, ev};
    assign end_res = {4'd0, {MANT_BITS{1'b0}}, 8'd0, end_ev};

    always_comb begin
        priority if (have_num) begin
            res0 = {res_n == 2'd1, num_res};
        end else if (emit_ev) begin
            res0 = {res_n == 2'd1, ev_res};
        end else begin
            res0 = {1'b1, end_res};
        end
        res1 = (have_num && emit_ev) ? {1'b1, ev_res} : {1'b1, end_res};
    end

    // Ignore input after an error until the last item
    assign halt_next = acc ? ((halt_reg || err) && !last) : halt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            halt_reg <= 1'b0;
        end else begin
            halt_reg <= halt_next;
        end
    end

    bmnl_res_fifo #(
        .W     (RES_W),
        .DEPTH (bmnl_pkg::RES_DEPTH)
    ) u_res_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_n     (wr_n),
        .wr_data0 (res0),
        .wr_data1 (res1),
        .room2    (room2),
        .rd_valid (m_tvalid),
        .rd_ready (m_tready),
        .rd_data  (rd_res)
    );

    // Unpack the result item onto the stream
    assign s_tready = room2;
    assign m_tuser  = rd_res[3:0];
    assign m_tdata  = TDATA_W'(rd_res[RES_W-2:4]);
    assign m_tlast  = rd_res[RES_W-1];

    `BMNL_ASSERT_SAME(a_halt_silent, aclk, aresetn, acc && halt_reg, wr_n == 2'd0,
        "halted block produced a result")
    `BMNL_ASSERT_NEXT(a_err_halts, aclk, aresetn, acc && !halt_reg && err && !last,
        halt_reg, "error did not halt the block")
    `BMNL_ASSERT_NEXT(a_last_resets, aclk, aresetn, acc && last,
        stk_stat.empty && !halt_reg, "last item did not reset the block")
    `BMNL_ASSERT_SAME(a_end_once, aclk, aresetn, acc && !halt_reg && last,
        res_n != 2'd0, "last item gave no result")

endmodule

// ===== bench/tb_top.sv =====
module tb_top;

    localparam int DEPTH    = 64;
    localparam int MANT_W   = 40;
    localparam int TDATA_W  = ((8 + MANT_W + 4 + 7) / 8) * 8;
    localparam int WATCHDOG = 4000;
    localparam int PER_PHASE = 150;
    localparam logic [63:0] MANT_LIM = (64'd1 << MANT_W) - 64'd1;

    localparam logic [7:0] OPS [4]      = '{bmnl_pkg::CH_PLUS, bmnl_pkg::CH_MINUS,
                                            bmnl_pkg::CH_STAR, bmnl_pkg::CH_SLASH};
    localparam logic [7:0] OPENERS [3]  = '{bmnl_pkg::CH_LPAREN, bmnl_pkg::CH_LBRACK,
                                            bmnl_pkg::CH_LBRACE};
    localparam logic [7:0] CLOSERS [3]  = '{bmnl_pkg::CH_RPAREN, bmnl_pkg::CH_RBRACK,
                                            bmnl_pkg::CH_RBRACE};
    localparam int SEND_IDLE [4] = '{0, 56, 0, 14};
    localparam int RECV_STALL [4] = '{0, 0, 56, 14};

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [7:0]         s_tdata = 8'd0;
    logic               s_tlast = 1'b0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [TDATA_W-1:0] m_tdata;
    logic [3:0]         m_tuser;
    logic               m_tlast;

    int idle_pct = 0;
    int stall_pct = 0;
    int live_items = 0;
    int quiet = 0;
    logic [7:0] line_buf[$];

    // One expected token on the result side
    typedef struct {
        bmnl_pkg::ev_t     ev;
        logic [7:0]        sym;
        logic [MANT_W-1:0] mant;
        logic [3:0]        frac;
        logic              last;
    } lex_token_t;

    // Track lexer state and hold the tokens still due
    class lex_tracker;
        lex_token_t due_tokens[$];
        int         faults;
        logic [1:0] nest [DEPTH];
        int         depth;
        logic [63:0] acc;
        logic [3:0] frac_cnt;
        bit         in_frac;
        bit         in_num;
        bit         halted;

        function new();
            faults = 0;
            clear_all();
        endfunction

        function void clear_number();
            acc = 64'd0;
            frac_cnt = 4'd0;
            in_frac = 1'b0;
            in_num = 1'b0;
        endfunction

        function void clear_all();
            depth = 0;
            halted = 1'b0;
            clear_number();
        endfunction

        function logic [1:0] kind_of(logic [7:0] c);
            case (c)
                bmnl_pkg::CH_LPAREN, bmnl_pkg::CH_RPAREN: return bmnl_pkg::BR_PAREN;
                bmnl_pkg::CH_LBRACK, bmnl_pkg::CH_RBRACK: return bmnl_pkg::BR_SQUARE;
                default:                                  return bmnl_pkg::BR_CURLY;
            endcase
        endfunction

        function void add(bmnl_pkg::ev_t ev, logic [7:0] sym, logic [63:0] m,
                          logic [3:0] f);
            lex_token_t t;
            t.ev = ev;
            t.sym = sym;
            t.mant = m[MANT_W-1:0];
            t.frac = f;
            t.last = 1'b0;
            due_tokens.push_back(t);
        endfunction

        // Emit the pending number, if any, and start a fresh one
        function bit emit_number();
            bit had;
            had = in_num;
            if (had)
                add(bmnl_pkg::EV_NUMBER, 8'd0, acc, frac_cnt);
            clear_number();
            return had;
        endfunction

        // Accumulate one digit, saturating the mantissa
        function void push_digit(logic [63:0] d);
            in_num = 1'b1;
            if (in_frac) begin
                if (frac_cnt == bmnl_pkg::FRAC_MAX)
                    return;
                frac_cnt++;
            end
            if (acc > (MANT_LIM - d) / 64'd10)
                acc = MANT_LIM;
            else
                acc = acc * 64'd10 + d;
        endfunction

        // Note one accepted character; returns 0 when the lexer drops it
        function bit take_char(logic [7:0] c, logic fin);
            bmnl_pkg::ev_t ev;
            bit  has_ev;
            bit  err;
            bit  had_num;
            int  n0;
            ev = bmnl_pkg::EV_OPEN;
            has_ev = 1'b0;
            err = 1'b0;
            had_num = 1'b0;
            n0 = due_tokens.size();
            if (halted) begin
                if (fin)
                    clear_all();
                return 1'b0;
            end
            if (c >= bmnl_pkg::CH_ZERO && c <= bmnl_pkg::CH_NINE) begin
                push_digit(64'(c - bmnl_pkg::CH_ZERO));
            end else if (c == bmnl_pkg::CH_POINT) begin
                in_num = 1'b1;
                in_frac = 1'b1;
            end else begin
                had_num = emit_number();
                if (c == bmnl_pkg::CH_LPAREN || c == bmnl_pkg::CH_LBRACK
                        || c == bmnl_pkg::CH_LBRACE) begin
                    has_ev = 1'b1;
                    if (depth >= DEPTH) begin
                        ev = bmnl_pkg::EV_OVERFLOW;
                        err = 1'b1;
                    end else begin
                        nest[depth] = kind_of(c);
                        depth++;
                        ev = bmnl_pkg::EV_OPEN;
                    end
                end else if (c == bmnl_pkg::CH_RPAREN || c == bmnl_pkg::CH_RBRACK
                        || c == bmnl_pkg::CH_RBRACE) begin
                    has_ev = 1'b1;
                    if (depth == 0) begin
                        ev = bmnl_pkg::EV_CLOSE_EMPTY;
                        err = 1'b1;
                    end else begin
                        depth--;
                        if (nest[depth] == kind_of(c)) begin
                            ev = bmnl_pkg::EV_CLOSE_MATCH;
                        end else begin
                            ev = bmnl_pkg::EV_MISMATCH;
                            err = 1'b1;
                        end
                    end
                end else if (c == bmnl_pkg::CH_PLUS || c == bmnl_pkg::CH_MINUS
                        || c == bmnl_pkg::CH_STAR || c == bmnl_pkg::CH_SLASH) begin
                    has_ev = 1'b1;
                    ev = bmnl_pkg::EV_OPERATOR;
                end
            end
            // Errors win over the end of the expression
            if (err) begin
                add(ev, c, 64'd0, 4'd0);
                if (fin)
                    clear_all();
                else
                    halted = 1'b1;
            end else if (fin) begin
                if (emit_number())
                    had_num = 1'b1;
                if (has_ev && !had_num)
                    add(ev, c, 64'd0, 4'd0);
                add(depth > 0 ? bmnl_pkg::EV_UNCLOSED : bmnl_pkg::EV_END_OK,
                    8'd0, 64'd0, 4'd0);
                clear_all();
            end else if (has_ev) begin
                add(ev, c, 64'd0, 4'd0);
            end
            if (due_tokens.size() > n0)
                due_tokens[due_tokens.size() - 1].last = 1'b1;
            return 1'b1;
        endfunction

        // Compare one result against the oldest token due
        function void match_token(logic [3:0] ev, logic [7:0] sym, logic [MANT_W-1:0] mant,
                                  logic [3:0] frac, logic last);
            lex_token_t t;
            if (due_tokens.size() == 0) begin
                faults++;
                if (faults <= 10)
                    $display("unexpected result: ev %0d sym %02h mant %0d frac %0d last %0b",
                             ev, sym, mant, frac, last);
                return;
            end
            t = due_tokens.pop_front();
            if (t.ev !== ev || t.sym !== sym || t.mant !== mant || t.frac !== frac
                    || t.last !== last) begin
                faults++;
                if (faults <= 10)
                    $display("mismatch: expected ev %0d sym %02h mant %0d frac %0d last %0b, %s",
                             t.ev, t.sym, t.mant, t.frac, t.last, "got");
                if (faults <= 10)
                    $display("          actual   ev %0d sym %02h mant %0d frac %0d last %0b",
                             ev, sym, mant, frac, last);
            end
        endfunction
    endclass

    lex_tracker lexer = new();

    bracket_match_number_lexer #(
        .STACK_DEPTH(DEPTH),
        .MANT_BITS  (MANT_W)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Stall the result side at random
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Note accepted items, check results, watch for a hang
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            if (lexer.take_char(s_tdata, s_tlast))
                live_items++;
        end
        if (aresetn && m_tvalid && m_tready)
            lexer.match_token(m_tuser, m_tdata[7:0], m_tdata[8 +: MANT_W],
                              m_tdata[8 + MANT_W +: 4], m_tlast);
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet = 0;
        else
            quiet++;
        if (quiet >= WATCHDOG) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Offer one item, idling first at random; returns at the falling edge after acceptance
    task automatic send_char(input logic [7:0] c, input logic fin);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= c;
        s_tlast <= fin;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        @(negedge aclk);
    endtask

    // Send the buffered expression, marking its final character
    task automatic send_line();
        foreach (line_buf[i])
            send_char(line_buf[i], i == line_buf.size() - 1);
        line_buf.delete();
    endtask

    function automatic void put_digit();
        line_buf.push_back(bmnl_pkg::CH_ZERO + 8'($urandom_range(9)));
    endfunction

    // Append a number of a random shape
    function automatic void put_number();
        int    style;
        string near_lim;
        style = $urandom_range(99);
        near_lim = "109951162777";
        if (style < 40) begin
            repeat ($urandom_range(1, 4)) put_digit();
        end else if (style < 62) begin
            repeat ($urandom_range(1, 3)) put_digit();
            line_buf.push_back(bmnl_pkg::CH_POINT);
            repeat ($urandom_range(1, 4)) put_digit();
        end else if (style < 68) begin
            // lone point
            line_buf.push_back(bmnl_pkg::CH_POINT);
        end else if (style < 74) begin
            line_buf.push_back(bmnl_pkg::CH_POINT);
            repeat ($urandom_range(1, 3)) put_digit();
        end else if (style < 80) begin
            // second point in the same number
            put_digit();
            line_buf.push_back(bmnl_pkg::CH_POINT);
            put_digit();
            line_buf.push_back(bmnl_pkg::CH_POINT);
            put_digit();
        end else if (style < 85) begin
            // straddle the mantissa limit
            foreach (near_lim[i])
                line_buf.push_back(near_lim[i]);
            put_digit();
        end else if (style < 92) begin
            if ($urandom_range(1))
                repeat ($urandom_range(12, 18)) line_buf.push_back(bmnl_pkg::CH_NINE);
            else
                repeat ($urandom_range(12, 18)) put_digit();
        end else begin
            // fraction up to and past the digit counter limit
            put_digit();
            line_buf.push_back(bmnl_pkg::CH_POINT);
            repeat ($urandom_range(14, 19)) put_digit();
        end
    endfunction

    // Build and send one expression, mostly well nested
    task automatic run_expression();
        logic [7:0] closers[$];
        int         pick;
        int         k;
        repeat ($urandom_range(1, 12)) begin
            pick = $urandom_range(99);
            if (pick < 22) begin
                k = $urandom_range(2);
                line_buf.push_back(OPENERS[k]);
                closers.push_back(CLOSERS[k]);
            end else if (pick < 40 && closers.size() > 0) begin
                line_buf.push_back(closers.pop_back());
            end else if (pick < 65) begin
                put_number();
            end else if (pick < 80) begin
                line_buf.push_back(OPS[$urandom_range(3)]);
            end else if (pick < 86) begin
                line_buf.push_back($urandom_range(1) ? 8'h20 : "a" + 8'($urandom_range(25)));
            end else if (pick < 92) begin
                line_buf.push_back(8'($urandom_range(255)));
            end else if (pick < 95) begin
                // stray close: mismatch or close on empty most of the time
                line_buf.push_back(CLOSERS[$urandom_range(2)]);
            end else begin
                put_number();
            end
        end
        if ($urandom_range(99) < 75) begin
            while (closers.size() > 0)
                line_buf.push_back(closers.pop_back());
        end
        if ($urandom_range(99) < 30) begin
            pick = $urandom_range(2);
            if (pick == 0)
                put_number();
            else if (pick == 1)
                line_buf.push_back(OPS[$urandom_range(3)]);
            else
                line_buf.push_back(OPENERS[$urandom_range(2)]);
        end
        send_line();
    endtask

    // Nest n_open brackets deep, then unwind or trail off after an overflow
    task automatic run_deep(input int n_open);
        logic [7:0] closers[$];
        int         k;
        repeat (n_open) begin
            k = $urandom_range(2);
            line_buf.push_back(OPENERS[k]);
            closers.push_back(CLOSERS[k]);
        end
        if (n_open <= DEPTH) begin
            put_number();
            while (closers.size() > 0)
                line_buf.push_back(closers.pop_back());
        end else begin
            repeat ($urandom_range(1, 4)) line_buf.push_back(8'($urandom_range(255)));
        end
        send_line();
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (int p = 0; p < 4; p++) begin
            idle_pct = SEND_IDLE[p];
            stall_pct = RECV_STALL[p];
            if (p == 0) begin
                // Every bracket and operator, point handling, end and error paths
                line_buf = '{8'h00, bmnl_pkg::CH_LPAREN, bmnl_pkg::CH_LBRACK,
                             bmnl_pkg::CH_LBRACE, bmnl_pkg::CH_RBRACE,
                             bmnl_pkg::CH_RBRACK, bmnl_pkg::CH_RPAREN,
                             bmnl_pkg::CH_PLUS, bmnl_pkg::CH_MINUS,
                             bmnl_pkg::CH_STAR, bmnl_pkg::CH_SLASH,
                             bmnl_pkg::CH_ZERO + 8'd1, bmnl_pkg::CH_POINT,
                             bmnl_pkg::CH_ZERO + 8'd5, bmnl_pkg::CH_POINT,
                             bmnl_pkg::CH_NINE, 8'hFF, bmnl_pkg::CH_POINT,
                             bmnl_pkg::CH_SLASH, bmnl_pkg::CH_LPAREN,
                             bmnl_pkg::CH_ZERO + 8'd7, bmnl_pkg::CH_RPAREN};
                send_line();
                line_buf = '{bmnl_pkg::CH_RBRACK, "x", bmnl_pkg::CH_LPAREN};
                send_line();
                line_buf = '{bmnl_pkg::CH_LBRACE};
                send_line();
                run_deep(DEPTH + 1);
            end
            if (p == 2)
                run_deep(DEPTH);
            k_loop: while (live_items < (p + 1) * PER_PHASE + 200) begin
                if ($urandom_range(99) < 8) begin
                    repeat ($urandom_range(1, 8)) line_buf.push_back(8'($urandom_range(255)));
                    send_line();
                end else begin
                    run_expression();
                end
            end
        end
        s_tvalid <= 1'b0;

        // Drain, then give the block time to show anything stray
        while (lexer.due_tokens.size() != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (lexer.faults == 0 && lexer.due_tokens.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
